// ----- rtl/rcf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, constants and helpers of the rgb color filter pipeline.
// ----------------------------------------------------------------------------
package rcf_pkg;

  // filter mode codes
  typedef enum logic [3:0] {
    MODE_PASS   = 4'd0,
    MODE_GRAY   = 4'd1,
    MODE_SEPIA  = 4'd2,
    MODE_INVERT = 4'd3,
    MODE_BRIGHT = 4'd4,
    MODE_COOL   = 4'd5,
    MODE_WARM   = 4'd6,
    MODE_GOLD   = 4'd7,
    MODE_NOIR   = 4'd8,
    MODE_VIVID  = 4'd9,
    MODE_BLUE   = 4'd10
  } filter_mode_e;

  // divisor applied to a channel numerator
  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_100  = 2'd1,
    DIV_1000 = 2'd2
  } div_kind_e;

  // per-item control that travels with the numerators
  typedef struct packed {
    div_kind_e kind;
    logic      noir;
  } rcf_ctl_t;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumW   = 19;  // largest numerator is 1351 * 255
  localparam int unsigned MagicW = 20;
  localparam int unsigned ProdW  = NumW + MagicW;
  localparam int unsigned QuotW  = 10;  // quotients stay below 1024

  // reciprocal constants: floor(n * m / 2^s) is exact over the numerator range
  localparam logic [MagicW-1:0] MagicDiv1000 = 20'd536871;
  localparam int unsigned       ShiftDiv1000 = 29;
  localparam logic [MagicW-1:0] MagicDiv100  = 20'd83887;
  localparam int unsigned       ShiftDiv100  = 23;
  localparam logic [MagicW-1:0] MagicOne     = 20'd1;

  localparam logic [ChanW-1:0] ChanMax    = 8'd255;
  localparam logic [ChanW-1:0] BrightAdd  = 8'd30;
  localparam logic [QuotW:0]   NoirBias   = 11'd64;

  // weighted sum of three channels, coefficients in thousandths
  function automatic logic [NumW-1:0] mat3(
    input logic [ChanW-1:0] r,
    input logic [ChanW-1:0] g,
    input logic [ChanW-1:0] b,
    input logic [9:0]       kr,
    input logic [9:0]       kg,
    input logic [9:0]       kb
  );
    logic [NumW-1:0] pr;
    logic [NumW-1:0] pg;
    logic [NumW-1:0] pb;
    pr = {{(NumW-ChanW){1'b0}}, r} * {{(NumW-10){1'b0}}, kr};
    pg = {{(NumW-ChanW){1'b0}}, g} * {{(NumW-10){1'b0}}, kg};
    pb = {{(NumW-ChanW){1'b0}}, b} * {{(NumW-10){1'b0}}, kb};
    return pr + pg + pb;
  endfunction

  // c * k + offset * 100, to be divided by 100
  function automatic logic [NumW-1:0] scale_num(
    input logic [ChanW-1:0] c,
    input logic [7:0]       k,
    input logic [11:0]      off100
  );
    logic [NumW-1:0] p;
    p = {{(NumW-ChanW){1'b0}}, c} * {{(NumW-8){1'b0}}, k};
    return p + {{(NumW-12){1'b0}}, off100};
  endfunction

  // plain channel value carried through the divider untouched
  function automatic logic [NumW-1:0] direct_num(input logic [ChanW:0] v);
    return {{(NumW-ChanW-1){1'b0}}, v};
  endfunction

endpackage

// ----- rtl/rcf_div.sv -----
// ----------------------------------------------------------------------------
// rcf_div
// Two-stage channel back end: reciprocal multiply, then shift, noir mapping
// and saturation into an 8-bit output register.
// ----------------------------------------------------------------------------
module rcf_div (
  input  logic                          clk_i,
  input  logic [rcf_pkg::NumW-1:0]      num_i,
  input  rcf_pkg::rcf_ctl_t             ctl_i,
  output logic [rcf_pkg::ChanW-1:0]     value_o
);

  logic [rcf_pkg::MagicW-1:0] magic;
  logic [rcf_pkg::ProdW-1:0]  prod_d, prod_q;
  rcf_pkg::rcf_ctl_t          ctl_q;
  logic [rcf_pkg::QuotW-1:0]  quot;
  logic [rcf_pkg::QuotW:0]    noir_sum;
  logic [rcf_pkg::QuotW:0]    noir_val;
  logic [rcf_pkg::QuotW:0]    pre_sat;
  logic [rcf_pkg::ChanW-1:0]  value_d, value_q;

  // pick the reciprocal for this item
  always_comb begin
    unique case (ctl_i.kind)
      rcf_pkg::DIV_1000: magic = rcf_pkg::MagicDiv1000;
      rcf_pkg::DIV_100:  magic = rcf_pkg::MagicDiv100;
      rcf_pkg::DIV_NONE: magic = rcf_pkg::MagicOne;
      default:           magic = rcf_pkg::MagicOne;
    endcase
  end

  assign prod_d = {{rcf_pkg::MagicW{1'b0}}, num_i} * {{rcf_pkg::NumW{1'b0}}, magic};

  // multiply stage
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    ctl_q  <= ctl_i;
  end

  // quotient by shift
  always_comb begin
    unique case (ctl_q.kind)
      rcf_pkg::DIV_1000:
        quot = prod_q[rcf_pkg::ShiftDiv1000 +: rcf_pkg::QuotW];
      rcf_pkg::DIV_100:
        quot = prod_q[rcf_pkg::ShiftDiv100 +: rcf_pkg::QuotW];
      rcf_pkg::DIV_NONE:
        quot = prod_q[rcf_pkg::QuotW-1:0];
      default:
        quot = prod_q[rcf_pkg::QuotW-1:0];
    endcase
  end

  // noir: floor(3y/2) - 64, clamped at zero
  assign noir_sum = {1'b0, quot} + {2'b0, quot[rcf_pkg::QuotW-1:1]};
  assign noir_val = (noir_sum < rcf_pkg::NoirBias) ? '0 : (noir_sum - rcf_pkg::NoirBias);

  // saturate at full scale
  always_comb begin
    pre_sat = ctl_q.noir ? noir_val : {1'b0, quot};
    if (pre_sat > {{(rcf_pkg::QuotW+1-rcf_pkg::ChanW){1'b0}}, rcf_pkg::ChanMax}) begin
      value_d = rcf_pkg::ChanMax;
    end else begin
      value_d = pre_sat[rcf_pkg::ChanW-1:0];
    end
  end

  // output stage
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- rtl/rgb_color_filter_modes.sv -----
// ----------------------------------------------------------------------------
// rgb_color_filter_modes
// Per-pixel color filter with a mode register, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: an item (red, green, blue, alpha, last pixel mark) is taken
//   at each rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so a new item may enter on every clock.
//   Result channel: result_valid_o is high for exactly one cycle per item, with
//   the filtered pixel on the result ports; the receiver cannot stall it.
//   Throughput one item per cycle. The path is input register, numerator
//   register, reciprocal multiply register, output register; the 19 x 20 bit
//   reciprocal multiply sets the depth of the third stage.
//   Mode register: filter_mode_we_i writes filter_mode_i at a rising edge. The
//   mode is sampled with each item as it enters, so items in flight keep the
//   mode they were accepted under.
//   Reset clears the mode to pass through and empties the pipeline; results in
//   flight at reset are dropped.
// ----------------------------------------------------------------------------
module rgb_color_filter_modes (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       filter_mode_we_i,
  input  logic [3:0] filter_mode_i,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  input  logic       last_pixel_in_i,
  output logic       result_valid_o,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [7:0] alpha_out_o,
  output logic       last_pixel_out_o
);

  localparam int unsigned SideW = rcf_pkg::ChanW + 1;  // alpha and last mark

  logic [3:0]                 filter_mode_q;
  logic                       accept;

  logic                       v1_q, v2_q, v3_q, v4_q;
  logic [3:0]                 s1_mode_q;
  logic [rcf_pkg::ChanW-1:0]  s1_r_q, s1_g_q, s1_b_q;
  logic [SideW-1:0]           s1_side_q, s2_side_q, s3_side_q, s4_side_q;

  logic [rcf_pkg::NumW-1:0]   num_r_d, num_g_d, num_b_d;
  logic [rcf_pkg::NumW-1:0]   num_r_q, num_g_q, num_b_q;
  rcf_pkg::rcf_ctl_t          ctl_d, ctl_q;
  logic [rcf_pkg::NumW-1:0]   luma_num;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= rcf_pkg::MODE_PASS;
    end else if (filter_mode_we_i) begin
      filter_mode_q <= filter_mode_i;
    end
  end

  // valid bits through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // input stage and side channel delay line
  always_ff @(posedge clk_i) begin
    s1_mode_q <= filter_mode_q;
    s1_r_q    <= red_in_i;
    s1_g_q    <= green_in_i;
    s1_b_q    <= blue_in_i;
    s1_side_q <= {last_pixel_in_i, alpha_in_i};
    s2_side_q <= s1_side_q;
    s3_side_q <= s2_side_q;
    s4_side_q <= s3_side_q;
  end

  assign luma_num = rcf_pkg::mat3(s1_r_q, s1_g_q, s1_b_q, 10'd299, 10'd587, 10'd114);

  // numerator per channel and divisor choice
  always_comb begin
    ctl_d.kind = rcf_pkg::DIV_NONE;
    ctl_d.noir = 1'b0;
    num_r_d    = rcf_pkg::direct_num({1'b0, s1_r_q});
    num_g_d    = rcf_pkg::direct_num({1'b0, s1_g_q});
    num_b_d    = rcf_pkg::direct_num({1'b0, s1_b_q});
    unique case (s1_mode_q)
      rcf_pkg::MODE_GRAY, rcf_pkg::MODE_NOIR: begin
        ctl_d.kind = rcf_pkg::DIV_1000;
        ctl_d.noir = (s1_mode_q == rcf_pkg::MODE_NOIR);
        num_r_d    = luma_num;
        num_g_d    = luma_num;
        num_b_d    = luma_num;
      end
      rcf_pkg::MODE_SEPIA: begin
        ctl_d.kind = rcf_pkg::DIV_1000;
        num_r_d = rcf_pkg::mat3(s1_r_q, s1_g_q, s1_b_q, 10'd393, 10'd769, 10'd189);
        num_g_d = rcf_pkg::mat3(s1_r_q, s1_g_q, s1_b_q, 10'd349, 10'd686, 10'd168);
        num_b_d = rcf_pkg::mat3(s1_r_q, s1_g_q, s1_b_q, 10'd272, 10'd534, 10'd131);
      end
      rcf_pkg::MODE_INVERT: begin
        num_r_d = rcf_pkg::direct_num({1'b0, rcf_pkg::ChanMax - s1_r_q});
        num_g_d = rcf_pkg::direct_num({1'b0, rcf_pkg::ChanMax - s1_g_q});
        num_b_d = rcf_pkg::direct_num({1'b0, rcf_pkg::ChanMax - s1_b_q});
      end
      rcf_pkg::MODE_BRIGHT: begin
        num_r_d = rcf_pkg::direct_num({1'b0, s1_r_q} + {1'b0, rcf_pkg::BrightAdd});
        num_g_d = rcf_pkg::direct_num({1'b0, s1_g_q} + {1'b0, rcf_pkg::BrightAdd});
        num_b_d = rcf_pkg::direct_num({1'b0, s1_b_q} + {1'b0, rcf_pkg::BrightAdd});
      end
      rcf_pkg::MODE_COOL: begin
        ctl_d.kind = rcf_pkg::DIV_100;
        num_r_d = rcf_pkg::scale_num(s1_r_q, 8'd90, 12'd0);
        num_g_d = rcf_pkg::scale_num(s1_g_q, 8'd95, 12'd0);
        num_b_d = rcf_pkg::scale_num(s1_b_q, 8'd110, 12'd1000);
      end
      rcf_pkg::MODE_WARM: begin
        ctl_d.kind = rcf_pkg::DIV_100;
        num_r_d = rcf_pkg::scale_num(s1_r_q, 8'd120, 12'd0);
        num_g_d = rcf_pkg::scale_num(s1_g_q, 8'd100, 12'd0);
        num_b_d = rcf_pkg::scale_num(s1_b_q, 8'd110, 12'd2000);
      end
      rcf_pkg::MODE_GOLD: begin
        ctl_d.kind = rcf_pkg::DIV_100;
        num_r_d = rcf_pkg::scale_num(s1_r_q, 8'd110, 12'd1000);
        num_g_d = rcf_pkg::scale_num(s1_g_q, 8'd105, 12'd500);
        num_b_d = rcf_pkg::scale_num(s1_b_q, 8'd85, 12'd0);
      end
      rcf_pkg::MODE_VIVID: begin
        ctl_d.kind = rcf_pkg::DIV_100;
        num_r_d = rcf_pkg::scale_num(s1_r_q, 8'd130, 12'd1500);
        num_g_d = rcf_pkg::scale_num(s1_g_q, 8'd110, 12'd0);
        num_b_d = rcf_pkg::scale_num(s1_b_q, 8'd90, 12'd0);
      end
      rcf_pkg::MODE_BLUE: begin
        ctl_d.kind = rcf_pkg::DIV_100;
        num_r_d = rcf_pkg::scale_num(s1_r_q, 8'd70, 12'd0);
        num_g_d = rcf_pkg::scale_num(s1_g_q, 8'd85, 12'd0);
        num_b_d = rcf_pkg::scale_num(s1_b_q, 8'd140, 12'd2000);
      end
      default: begin
        // pass through modes keep the direct values
        ctl_d.kind = rcf_pkg::DIV_NONE;
      end
    endcase
  end

  // numerator stage
  always_ff @(posedge clk_i) begin
    num_r_q <= num_r_d;
    num_g_q <= num_g_d;
    num_b_q <= num_b_d;
    ctl_q   <= ctl_d;
  end

  // divide, map and saturate each channel
  rcf_div u_div_r (
    .clk_i   (clk_i),
    .num_i   (num_r_q),
    .ctl_i   (ctl_q),
    .value_o (red_out_o)
  );

  rcf_div u_div_g (
    .clk_i   (clk_i),
    .num_i   (num_g_q),
    .ctl_i   (ctl_q),
    .value_o (green_out_o)
  );

  rcf_div u_div_b (
    .clk_i   (clk_i),
    .num_i   (num_b_q),
    .ctl_i   (ctl_q),
    .value_o (blue_out_o)
  );

  assign result_valid_o   = v4_q;
  assign alpha_out_o      = s4_side_q[rcf_pkg::ChanW-1:0];
  assign last_pixel_out_o = s4_side_q[rcf_pkg::ChanW];

`ifndef NO_ASSERTIONS
  // one result strobe for each accepted item, and none without one
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni, 1) && $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4))
    |-> (result_valid_o == $past(accept, 4)))
    else $error("result strobe does not follow accepted item");

  // side fields stay aligned with their item
  a_side_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(rst_ni, 4))
    |-> (alpha_out_o == $past(alpha_in_i, 4) && last_pixel_out_o == $past(last_pixel_in_i, 4)))
    else $error("alpha or last mark out of step with color channels");

  // gray modes give equal channels
  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(filter_mode_q == rcf_pkg::MODE_GRAY ||
                             filter_mode_q == rcf_pkg::MODE_NOIR, 4))
    |-> (red_out_o == green_out_o && green_out_o == blue_out_o))
    else $error("gray mode gave unequal channels");

  // invert mode complements each channel; red and blue are checked
  a_invert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(filter_mode_q == rcf_pkg::MODE_INVERT, 4))
    |-> (red_out_o == ~$past(red_in_i, 4) && blue_out_o == ~$past(blue_in_i, 4)))
    else $error("invert mode result is not the complement");
`endif

endmodule
